[hw/rtl/rme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants for the modular exponentiation block
// Holds the register map and the handshake struct between cell row and top.
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int unsigned CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_MODULUS     = 2'd0,
      REG_PUBLIC_EXP  = 2'd1,
      REG_PRIVATE_EXP = 2'd2
   } reg_index_type;

   // control of one modular multiply in the cell row
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mul_ctrl_type;

endpackage

[hw/rtl/rsa_modexp_32.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modexp_32: modular exponentiation by right-to-left square and multiply
// Each multiply and square runs in the bit-cell multiplier row.
// The block takes no new item until the last is done; busy is high throughout.
// Special cases (zero or unit modulus, zero exponent) skip the multiplier row.
// Reset: registers to modulus 1, public 65537, private 1; control idles.
// The receiver cannot stall: rsp_valid is high for one cycle per item.
// ----------------------------------------------------------------------------
module rsa_modexp_32
   import rme_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic [31:0]              req_base,
   output logic                     rsp_valid,
   output logic [31:0]              rsp_result,
   output logic                     rsp_modulus_error,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int unsigned EB = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REDUCE, ST_MUL, ST_SQR, ST_WAIT_MUL, ST_WAIT_SQR, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [WORD_BITS-1:0] mod_ff, pub_ff, priv_ff;
   logic [WORD_BITS-1:0] acc_ff, sq_ff, exp_ff;
   logic [EB-1:0]        bit_ff;
   logic                 valid_ff, err_ff;
   logic [31:0]          res_ff;
   logic                 first_ff;

   logic                 mul_start;
   logic [WORD_BITS-1:0] mul_a, mul_b, product;
   mul_ctrl_type         mctl;
   logic                 wr_en;
   reg_index_type        wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en  = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_MODULUS:     csr_prdata = 32'(mod_ff);
         REG_PUBLIC_EXP:  csr_prdata = 32'(pub_ff);
         REG_PRIVATE_EXP: csr_prdata = 32'(priv_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // operands: sq*acc for a multiply, sq*sq for a square; base reduced by multiplying with 1
   always_comb begin
      mul_start = 1'b0;
      mul_a     = sq_ff;
      mul_b     = acc_ff;
      case (state_ff)
         ST_REDUCE: begin
            mul_start = 1'b1;
            mul_b     = WORD_BITS'(1);
         end
         ST_MUL:    mul_start = 1'b1;
         ST_SQR: begin
            mul_start = 1'b1;
            mul_b     = sq_ff;
         end
         default: ;
      endcase
   end

   rme_mulrow #(.WORD_BITS(WORD_BITS)) u_mulrow (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_ff),
      .ctrl    (mctl),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         mod_ff   <= WORD_BITS'(1);
         pub_ff   <= WORD_BITS'(65537);
         priv_ff  <= WORD_BITS'(1);
      end else begin
         valid_ff <= 1'b0;
         if (wr_en) begin
            case (wr_idx)
               REG_MODULUS:     mod_ff  <= csr_pwdata[WORD_BITS-1:0];
               REG_PUBLIC_EXP:  pub_ff  <= csr_pwdata[WORD_BITS-1:0];
               REG_PRIVATE_EXP: priv_ff <= csr_pwdata[WORD_BITS-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  exp_ff <= req_action ? priv_ff : pub_ff;
                  sq_ff  <= req_base[WORD_BITS-1:0];
                  acc_ff <= WORD_BITS'(1);
                  bit_ff <= '0;
                  err_ff <= 1'b0;
                  res_ff <= '0;
                  if (mod_ff == '0) begin
                     err_ff   <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (mod_ff == WORD_BITS'(1)) begin
                     state_ff <= ST_DONE;
                  end else if ((req_action ? priv_ff : pub_ff) == '0) begin
                     res_ff   <= 32'd1;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: state_ff <= ST_WAIT_SQR;
            ST_MUL:    state_ff <= ST_WAIT_MUL;
            ST_SQR:    state_ff <= ST_WAIT_SQR;
            ST_WAIT_MUL: begin
               if (mctl.done) begin
                  acc_ff   <= product;
                  state_ff <= ST_SQR;
               end
            end
            ST_WAIT_SQR: begin
               if (mctl.done) begin
                  sq_ff <= product;
                  if (first_ff) begin
                     state_ff <= exp_ff[0] ? ST_MUL : ST_SQR;
                  end else if (bit_ff == EB'(WORD_BITS - 1)) begin
                     res_ff   <= 32'(acc_ff);
                     state_ff <= ST_DONE;
                  end else begin
                     // exponent shifts at this edge, so the next bit is bit 1
                     state_ff <= exp_ff[1] ? ST_MUL : ST_SQR;
                  end
               end
            end
            ST_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         // exponent bit advances after each square, except the base reduction
         if (state_ff == ST_WAIT_SQR && mctl.done && !first_ff) begin
            exp_ff <= exp_ff >> 1;
            bit_ff <= bit_ff + 1'b1;
         end
      end
   end

   // the first square-wait holds the reduction, not a real square
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else if (state_ff == ST_REDUCE) begin
         first_ff <= 1'b1;
      end else if (mctl.done) begin
         first_ff <= 1'b0;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_result        = res_ff;
   assign rsp_modulus_error = err_ff;

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modulus_error |-> rsp_result == '0) else $error("error with result");
   a_idle_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mctl.busy) else $error("multiplier busy while idle");

endmodule

[hw/rtl/rme_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cell: one bit cell of the interleaved modular multiplier
// Holds one bit of the partial remainder; doubles, adds and subtracts.
// ----------------------------------------------------------------------------
module rme_cell (
   input  logic clock,
   input  logic load,
   input  logic step,
   input  logic rem_lo,
   input  logic add_bit,
   input  logic mod_bit,
   input  logic cin_add,
   input  logic bin_sub,
   input  logic bin_sub2,
   output logic rem_bit,
   output logic cout_add,
   output logic bout_sub,
   output logic bout_sub2,
   output logic sum_bit,
   output logic d1_bit,
   output logic d2_bit,
   input  logic sel_d1,
   input  logic sel_d2
);

   logic rem_ff;
   logic rem_in;

   // sum = 2*rem + addend (rem_lo is the lower neighbour bit)
   assign sum_bit  = rem_lo ^ add_bit ^ cin_add;
   assign cout_add = (rem_lo & add_bit) | (cin_add & (rem_lo ^ add_bit));
   // d1 = sum - n
   assign d1_bit   = sum_bit ^ mod_bit ^ bin_sub;
   assign bout_sub = (~sum_bit & mod_bit) | (bin_sub & ~(sum_bit ^ mod_bit));
   // d2 = d1 - n
   assign d2_bit    = d1_bit ^ mod_bit ^ bin_sub2;
   assign bout_sub2 = (~d1_bit & mod_bit) | (bin_sub2 & ~(d1_bit ^ mod_bit));

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = 1'b0;
      end else if (step) begin
         rem_in = sel_d2 ? d2_bit : (sel_d1 ? d1_bit : sum_bit);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign rem_bit = rem_ff;

endmodule

[hw/rtl/rme_mulrow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_mulrow: row of bit cells computing a * b mod n
// Interleaved method: one bit of a per cycle, msb first.
// ----------------------------------------------------------------------------
module rme_mulrow
   import rme_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   input  logic [WORD_BITS-1:0] modulus,
   output mul_ctrl_type         ctrl,
   output logic [WORD_BITS-1:0] product
);

   localparam int unsigned RB  = WORD_BITS + 2;
   localparam int unsigned CB  = $clog2(WORD_BITS + 1);

   logic [CB-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;

   logic [RB-1:0] rem, addv, modv, sumv, d1v, d2v;
   logic [RB:0]   ca, bs, bs2;
   logic [RB-1:0] rem_lo;
   logic          sel_d1, sel_d2, step;

   assign step = busy_ff;
   assign addv = a_ff[WORD_BITS-1] ? {2'b00, b_ff} : '0;
   assign modv = {2'b00, modulus};
   assign rem_lo = {rem[RB-2:0], 1'b0};
   assign ca[0]  = 1'b0;
   assign bs[0]  = 1'b0;
   assign bs2[0] = 1'b0;

   // sum < 3n, so at most two subtractions of n; d2 only counts when d1 is valid
   assign sel_d2 = ~bs[RB] & ~bs2[RB];
   assign sel_d1 = ~bs[RB];

   for (genvar g = 0; g < RB; g++) begin : g_cell
      rme_cell u_cell (
         .clock    (clock),
         .load     (start & ~busy_ff),
         .step     (step),
         .rem_lo   (rem_lo[g]),
         .add_bit  (addv[g]),
         .mod_bit  (modv[g]),
         .cin_add  (ca[g]),
         .bin_sub  (bs[g]),
         .bin_sub2 (bs2[g]),
         .rem_bit  (rem[g]),
         .cout_add (ca[g+1]),
         .bout_sub (bs[g+1]),
         .bout_sub2(bs2[g+1]),
         .sum_bit  (sumv[g]),
         .d1_bit   (d1v[g]),
         .d2_bit   (d2v[g]),
         .sel_d1   (sel_d1),
         .sel_d2   (sel_d2)
      );
   end

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CB'(WORD_BITS - 1);
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         a_in = {a_ff[WORD_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign product    = rem[WORD_BITS-1:0];

   logic unused_sum;
   assign unused_sum = ^{sumv[RB-1:WORD_BITS], d1v[RB-1:WORD_BITS], d2v[RB-1:WORD_BITS],
                         rem[RB-1:WORD_BITS], ca[RB], bs2[RB-1:0] == '0};

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rsa_modexp_32
// Drives base/action items with random gaps, writes the key registers over
// the apb port between phases, and checks every result against a modexp
// predictor computed in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import rme_pkg::*;

   typedef struct {
      logic        action;
      logic [31:0] base;
      int unsigned gap;
      logic        drain;
   } modexp_item_type;

   typedef struct {
      logic [31:0] result;
      logic        modulus_error;
   } modexp_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_action = 1'b0;
   logic [31:0]              req_base = '0;
   logic                     rsp_valid;
   logic [31:0]              rsp_result;
   logic                     rsp_modulus_error;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   modexp_item_type   pending_items[$];
   modexp_result_type expected_results[$];
   logic [31:0] key_modulus = 32'd1;
   logic [31:0] key_public = 32'd65537;
   logic [31:0] key_private = 32'd1;
   int unsigned failures = 0;
   int unsigned wait_count = 0;
   logic        drive_active = 1'b0;

   rsa_modexp_32 dut (.*);

   always #4 clock = ~clock;

   function automatic logic [31:0] mulmod(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] n);
      logic [63:0] product;
      product = {32'd0, a} * {32'd0, b};
      return 32'(product % {32'd0, n});
   endfunction

   function automatic modexp_result_type predict_modexp(input logic action,
                                                        input logic [31:0] base);
      modexp_result_type res;
      logic [31:0] exponent;
      logic [31:0] acc;
      logic [31:0] square;
      exponent = action ? key_private : key_public;
      res.modulus_error = 1'b0;
      if (key_modulus == 32'd0) begin
         res.result = '0;
         res.modulus_error = 1'b1;
      end else if (key_modulus == 32'd1) begin
         res.result = '0;
      end else if (exponent == 32'd0) begin
         res.result = 32'd1;
      end else begin
         acc = 32'd1;
         square = base % key_modulus;
         for (int i = 0; i < 32; i++) begin
            if (exponent[i]) acc = mulmod(acc, square, key_modulus);
            square = mulmod(square, square, key_modulus);
         end
         res.result = acc;
      end
      return res;
   endfunction

   // driver: optional drain, then gap, then hold start until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_results.push_back(predict_modexp(req_action, req_base));
            void'(pending_items.pop_front());
            wait_count <= 0;
            start <= 1'b0;
         end else if (!start && drive_active && pending_items.size() > 0) begin
            if (pending_items[0].drain && expected_results.size() > 0) begin
               wait_count <= 0;
            end else if (wait_count >= pending_items[0].gap) begin
               req_action <= pending_items[0].action;
               req_base <= pending_items[0].base;
               start <= 1'b1;
            end else begin
               wait_count <= wait_count + 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      modexp_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result %h", rsp_result);
            failures++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_result !== exp_res.result) begin
               $error("result: expected %h actual %h", exp_res.result, rsp_result);
               failures++;
            end
            if (rsp_modulus_error !== exp_res.modulus_error) begin
               $error("modulus_error: expected %b actual %b", exp_res.modulus_error,
                      rsp_modulus_error);
               failures++;
            end
         end
      end
   end

   task automatic write_key(input reg_index_type index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(4 * index);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_MODULUS:     key_modulus = value;
         REG_PUBLIC_EXP:  key_public = value;
         REG_PRIVATE_EXP: key_private = value;
         default: ;
      endcase
   endtask

   task automatic add_item(input logic action, input logic [31:0] base, input logic drain);
      modexp_item_type it;
      it.action = action;
      it.base = base;
      it.gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   // run a batch, then wait until idle so keys may change
   task automatic run_phase();
      drive_active = 1'b1;
      while (pending_items.size() > 0 || start) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      drive_active = 1'b0;
      repeat (2300) @(posedge clock);
   endtask

   task automatic random_keys();
      logic [31:0] n;
      case ($urandom_range(0, 9))
         0: n = 32'd0;
         1: n = 32'd1;
         2: n = 32'hFFFF_FFFF;
         3: n = $urandom_range(2, 300);
         default: n = $urandom;
      endcase
      write_key(REG_MODULUS, n);
      write_key(REG_PUBLIC_EXP, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
      write_key(REG_PRIVATE_EXP, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
   endtask

   initial begin
      logic [31:0] b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset keys: unit modulus
      add_item(1'b0, 32'hFFFF_FFFF, 1'b0);
      add_item(1'b1, 32'd0, 1'b0);
      run_phase();
      write_key(REG_MODULUS, 32'd0);
      add_item(1'b0, 32'h1234_5678, 1'b0);
      add_item(1'b1, 32'hFFFF_FFFF, 1'b0);
      run_phase();
      write_key(REG_MODULUS, 32'hFFFF_FFFB);
      write_key(REG_PUBLIC_EXP, 32'd0);
      write_key(REG_PRIVATE_EXP, 32'hFFFF_FFFF);
      // zero exponent on a multiple of the modulus still gives one
      add_item(1'b0, 32'hFFFF_FFFB, 1'b0);
      add_item(1'b0, 32'd0, 1'b0);
      add_item(1'b1, 32'hFFFF_FFFF, 1'b0);
      add_item(1'b1, 32'd0, 1'b0);
      add_item(1'b1, 32'd1, 1'b1);
      add_item(1'b1, 32'hFFFF_FFFB, 1'b0);
      run_phase();
      write_key(REG_MODULUS, 32'hFFFF_FFFF);
      write_key(REG_PUBLIC_EXP, 32'd65537);
      write_key(REG_PRIVATE_EXP, 32'd1);
      add_item(1'b0, 32'hFFFF_FFFE, 1'b0);
      add_item(1'b1, 32'hDEAD_BEEF, 1'b0);
      add_item(1'b0, 32'd2, 1'b0);
      run_phase();
      for (int phase = 0; phase < 25; phase++) begin
         random_keys();
         for (int i = 0; i < 10; i++) begin
            case ($urandom_range(0, 5))
               0: b = 32'd0;
               1: b = 32'hFFFF_FFFF;
               default: b = $urandom;
            endcase
            add_item(1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 19) == 0));
         end
         run_phase();
      end
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(64'd8 * 64'd4_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
